// File: src/ata_pkg.sv
package ata_pkg;

	localparam logic [63:0] Q30_HALF = 64'd536870912;
	localparam logic [63:0] COS1     = 64'd1073578288;
	localparam logic [63:0] SIN1     = 64'd18739379;
	localparam int          MAX_DEG  = 89;
	localparam logic [7:0]  RIGHT_DEG = 8'd90;
	localparam int          NUM_CELLS = 7;

	typedef logic [127:0][30:0] tab_t;

	typedef struct packed {
		logic [30:0] a2;
		logic [31:0] b2;
		logic        neg;
		logic [6:0]  deg;
	} ang_t;

	typedef struct packed {
		ang_t pitch;
		ang_t roll;
	} beat_t;

	function automatic tab_t build_tab(input logic want_sin);
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] nc;
		logic [63:0] ns;
		logic [63:0] c2;
		logic [63:0] s2;
		tab_t t;
		t = '0;
		c = COS1;
		s = SIN1;
		for (int k = 1; k <= MAX_DEG; k++) begin
			if (k > 1) begin
				nc = (c * COS1 - s * SIN1 + Q30_HALF) >> 30;
				ns = (s * COS1 + c * SIN1 + Q30_HALF) >> 30;
				c = nc;
				s = ns;
			end
			c2 = (c * c + Q30_HALF) >> 30;
			s2 = (s * s + Q30_HALF) >> 30;
			if (k == 45) begin
				c2 = Q30_HALF;
				s2 = Q30_HALF;
			end
			t[k] = want_sin ? s2[30:0] : c2[30:0];
		end
		return t;
	endfunction

	localparam tab_t COS2_TAB = build_tab(1'b0);
	localparam tab_t SIN2_TAB = build_tab(1'b1);

endpackage

// File: src/accel_tilt_angles_core.sv
// Accelerometer tilt core: pitch and roll in whole degrees, truncated toward zero.
// Input channel: in_valid / in_ready with six raw axis bytes (low, high per axis).
// Output channel: out_valid / out_ready with signed pitch_degrees and roll_degrees.
// Pipeline: one squaring stage, seven search cells and one output register.
// Each cell settles one bit of the angle by comparing a*a*cos2(k) with
// b2*sin2(k) against constant tables, for both angles in parallel.
// Each accepted beat passes the squaring register, the cell registers and
// the output register in that order before out_valid goes high.
// Throughput: one beat per cycle unless out_ready stalls; each cell takes a new
// beat whenever it is empty or its neighbor takes its beat, so bubbles collapse.
// When the receiver stalls, the chain fills and in_ready drops once all
// stages hold a beat; no beat is lost or repeated.
// Reset clears all valid flags; the data registers are not reset.
module accel_tilt_angles_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        x_low_byte,
	input  logic [7:0]        x_high_byte,
	input  logic [7:0]        y_low_byte,
	input  logic [7:0]        y_high_byte,
	input  logic [7:0]        z_low_byte,
	input  logic [7:0]        z_high_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] pitch_degrees,
	output logic signed [7:0] roll_degrees
);

	logic                v_c   [ata_pkg::NUM_CELLS+1];
	logic                rdy_c [ata_pkg::NUM_CELLS+1];
	ata_pkg::beat_t      d_c   [ata_pkg::NUM_CELLS+1];
	logic                ov_q;
	logic [7:0]          pitch_q, roll_q;
	logic                last_rdy;
	logic [7:0]          pm, rm;

	ata_prep u_prep (
		.clk(clk), .arst_n(arst_n), .vin(in_valid), .rdy(in_ready),
		.x_low_byte(x_low_byte), .x_high_byte(x_high_byte),
		.y_low_byte(y_low_byte), .y_high_byte(y_high_byte),
		.z_low_byte(z_low_byte), .z_high_byte(z_high_byte),
		.vout(v_c[0]), .dout(d_c[0]), .ready_nxt(rdy_c[0])
	);

	for (genvar i = 0; i < ata_pkg::NUM_CELLS; i++) begin : g_cell
		ata_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.bit_idx(3'(ata_pkg::NUM_CELLS - 1 - i)),
			.vin(v_c[i]), .rdy(rdy_c[i]), .din(d_c[i]),
			.vout(v_c[i+1]), .dout(d_c[i+1]), .ready_nxt(rdy_c[i+1])
		);
	end

	assign last_rdy = !ov_q || out_ready;
	assign rdy_c[ata_pkg::NUM_CELLS] = last_rdy;

	always_comb begin
		pm = {1'b0, d_c[ata_pkg::NUM_CELLS].pitch.deg};
		if (d_c[ata_pkg::NUM_CELLS].pitch.a2 == '0) pm = '0;
		else if (d_c[ata_pkg::NUM_CELLS].pitch.b2 == '0) pm = ata_pkg::RIGHT_DEG;
		if (d_c[ata_pkg::NUM_CELLS].pitch.neg) pm = 8'd0 - pm;
		rm = {1'b0, d_c[ata_pkg::NUM_CELLS].roll.deg};
		if (d_c[ata_pkg::NUM_CELLS].roll.a2 == '0) rm = '0;
		else if (d_c[ata_pkg::NUM_CELLS].roll.b2 == '0) rm = ata_pkg::RIGHT_DEG;
		if (d_c[ata_pkg::NUM_CELLS].roll.neg) rm = 8'd0 - rm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (last_rdy) begin
			ov_q <= v_c[ata_pkg::NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (last_rdy && v_c[ata_pkg::NUM_CELLS]) begin
			pitch_q <= pm;
			roll_q  <= rm;
		end
	end

	assign out_valid     = ov_q;
	assign pitch_degrees = pitch_q;
	assign roll_degrees  = roll_q;

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_degrees <= 8'sd90 && pitch_degrees >= -8'sd90))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_degrees <= 8'sd90 && roll_degrees >= -8'sd90))
		else $error("roll out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_degrees)
		&& $stable(roll_degrees))
		else $error("stalled beat changed");

	a_in_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

// File: src/ata_prep.sv
module ata_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vin,
	output logic              rdy,
	input  logic [7:0]        x_low_byte,
	input  logic [7:0]        x_high_byte,
	input  logic [7:0]        y_low_byte,
	input  logic [7:0]        y_high_byte,
	input  logic [7:0]        z_low_byte,
	input  logic [7:0]        z_high_byte,
	output logic              vout,
	output ata_pkg::beat_t    dout,
	input  logic              ready_nxt
);

	logic [15:0] xr, yr, zr, xm, ym, zm;
	logic [31:0] xx, yy, zz;
	logic        v_q;
	ata_pkg::beat_t d_s1;

	assign xr = {x_high_byte, x_low_byte};
	assign yr = {y_high_byte, y_low_byte};
	assign zr = {z_high_byte, z_low_byte};
	assign xm = xr[15] ? (~xr + 16'd1) : xr;
	assign ym = yr[15] ? (~yr + 16'd1) : yr;
	assign zm = zr[15] ? (~zr + 16'd1) : zr;
	assign xx = xm * xm;
	assign yy = ym * ym;
	assign zz = zm * zm;

	assign rdy = !v_q || ready_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vin) begin
			d_s1.pitch.a2  <= yy[30:0];
			d_s1.pitch.b2  <= xx + zz;
			d_s1.pitch.neg <= yr[15];
			d_s1.pitch.deg <= '0;
			d_s1.roll.a2   <= xx[30:0];
			d_s1.roll.b2   <= yy + zz;
			d_s1.roll.neg  <= xr[15];
			d_s1.roll.deg  <= '0;
		end
	end

	assign vout = v_q;
	assign dout = d_s1;

endmodule

// File: src/ata_cell.sv
module ata_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [2:0]     bit_idx,
	input  logic           vin,
	output logic           rdy,
	input  ata_pkg::beat_t din,
	output logic           vout,
	output ata_pkg::beat_t dout,
	input  logic           ready_nxt
);

	logic [6:0]  tp, tr;
	logic [62:0] lp, rp, lr, rr;
	logic        okp, okr;
	logic        v_q;
	ata_pkg::beat_t d_q;
	ata_pkg::beat_t d_nxt;

	assign tp = din.pitch.deg | (7'd1 << bit_idx);
	assign tr = din.roll.deg | (7'd1 << bit_idx);
	assign lp = din.pitch.a2 * ata_pkg::COS2_TAB[tp];
	assign rp = din.pitch.b2 * ata_pkg::SIN2_TAB[tp];
	assign lr = din.roll.a2 * ata_pkg::COS2_TAB[tr];
	assign rr = din.roll.b2 * ata_pkg::SIN2_TAB[tr];
	assign okp = (tp <= 7'(ata_pkg::MAX_DEG)) && (lp >= rp);
	assign okr = (tr <= 7'(ata_pkg::MAX_DEG)) && (lr >= rr);

	always_comb begin
		d_nxt = din;
		d_nxt.pitch.deg = okp ? tp : din.pitch.deg;
		d_nxt.roll.deg  = okr ? tr : din.roll.deg;
	end

	assign rdy = !v_q || ready_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && vin) begin
			d_q <= d_nxt;
		end
	end

	assign vout = v_q;
	assign dout = d_q;

endmodule

// File: tb/tb_accel_tilt_angles_core.sv
`timescale 1ns / 1ps

class tilt_scoreboard;
	typedef struct {
		logic signed [7:0] pitch;
		logic signed [7:0] roll;
	} tilt_t;

	tilt_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	static function logic [31:0] axis_square(logic [7:0] lo, logic [7:0] hi);
		logic signed [15:0] v;
		logic [16:0] m;
		v = {hi, lo};
		m = v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
		return 32'(m) * 32'(m);
	endfunction

	static function logic [7:0] tilt_degrees(logic [31:0] a2, logic [32:0] b2, logic neg);
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] nc;
		logic [63:0] ns;
		logic [63:0] c2;
		logic [63:0] s2;
		logic [127:0] lhs;
		logic [127:0] rhs;
		int deg;
		deg = 0;
		c = 64'd1073578288;
		s = 64'd18739379;
		if (a2 == 0)
			deg = 0;
		else if (b2 == 0)
			deg = 90;
		else begin
			for (int k = 1; k <= 89; k++) begin
				if (k > 1) begin
					nc = (c * 64'd1073578288 - s * 64'd18739379 + 64'd536870912) >> 30;
					ns = (s * 64'd1073578288 + c * 64'd18739379 + 64'd536870912) >> 30;
					c = nc;
					s = ns;
				end
				c2 = (c * c + 64'd536870912) >> 30;
				s2 = (s * s + 64'd536870912) >> 30;
				if (k == 45) begin
					c2 = 64'd536870912;
					s2 = 64'd536870912;
				end
				lhs = 128'(a2) * 128'(c2);
				rhs = 128'(b2) * 128'(s2);
				if (lhs >= rhs)
					deg = k;
				else
					break;
			end
		end
		return neg ? 8'(-deg) : 8'(deg);
	endfunction

	function void note_sample(logic [7:0] xl, logic [7:0] xh, logic [7:0] yl,
			logic [7:0] yh, logic [7:0] zl, logic [7:0] zh);
		logic [31:0] xx;
		logic [31:0] yy;
		logic [31:0] zz;
		tilt_t t;
		xx = axis_square(xl, xh);
		yy = axis_square(yl, yh);
		zz = axis_square(zl, zh);
		t.pitch = tilt_degrees(yy, 33'(xx) + 33'(zz), yh[7]);
		t.roll = tilt_degrees(xx, 33'(yy) + 33'(zz), xh[7]);
		pending.push_back(t);
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task check_angles(logic signed [7:0] pitch, logic signed [7:0] roll);
		tilt_t t;
		if (pending.size() == 0) begin
			report("unexpected beat", 0, 0);
			return;
		end
		t = pending.pop_front();
		if (pitch !== t.pitch)
			report("pitch", pitch, t.pitch);
		if (roll !== t.roll)
			report("roll", roll, t.roll);
	endtask
endclass

module tb_accel_tilt_angles_core;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] x_low_byte = '0;
	logic [7:0] x_high_byte = '0;
	logic [7:0] y_low_byte = '0;
	logic [7:0] y_high_byte = '0;
	logic [7:0] z_low_byte = '0;
	logic [7:0] z_high_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] pitch_degrees;
	logic signed [7:0] roll_degrees;

	tilt_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_recv = 1'b0;
	int quiet = 0;

	accel_tilt_angles_core uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_sample(x_low_byte, x_high_byte, y_low_byte, y_high_byte,
				z_low_byte, z_high_byte);
		if (out_valid && out_ready)
			sb.check_angles(pitch_degrees, roll_degrees);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);

	task send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{x_high_byte, x_low_byte} <= x;
		{y_high_byte, y_low_byte} <= y;
		{z_high_byte, z_low_byte} <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(5))
			0: return 16'($urandom_range(255));
			1: return 16'h8000 | 16'($urandom_range(3));
			2: return 16'h7FFF - 16'($urandom_range(3));
			3: return 16'($urandom_range(15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0100, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'hFF00, 16'h0000);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h7FFF, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h8000);
		send_sample(16'h0064, 16'h0000, 16'h0064);
		send_sample(16'hFF9C, 16'h0064, 16'h0000);
		send_sample(16'h0003, 16'h0004, 16'h0000);
		send_sample(16'h1234, 16'hEDCC, 16'h55AA);
		send_sample(16'hAA55, 16'h00FF, 16'hFF00);
		send_sample(16'h0001, 16'hFFFF, 16'h0001);
		send_sample(16'h7FFF, 16'h8000, 16'h0000);
		in_valid <= 1'b0;
		drain();
		hold_recv = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_recv = 1'b0;
			end
			begin
				repeat (40) send_sample(pick_axis(), pick_axis(), pick_axis());
				in_valid <= 1'b0;
			end
		join
		drain();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
			recv_idle = (phase == 0) ? 85 : (phase == 1) ? 27 : 0;
			repeat (265) send_sample(pick_axis(), pick_axis(), pick_axis());
			in_valid <= 1'b0;
			drain();
		end
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// File: accel_tilt_angles_core.f
src/ata_pkg.sv
src/ata_prep.sv
src/ata_cell.sv
src/accel_tilt_angles_core.sv
tb/tb_accel_tilt_angles_core.sv
